>>> src/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> src/mlf_pkg.sv
`default_nettype none
package mlf_pkg;
   localparam int TABLE_ENTRIES_DEF = 64;
   localparam int MAX_PORTS_DEF     = 16;
   localparam int MAC_W    = 48;
   localparam int PORT_W   = 4;
   localparam int TIME_W   = 32;
   localparam int MASK_W   = 16;
   localparam int PCNT_W   = 5;
   localparam int ENTRY_W  = MAC_W + PORT_W + TIME_W;
   localparam int REQ_W    = 136;
   localparam int RSP_W    = 24;

   localparam logic CSR_AGE_LIMIT  = 1'b0;
   localparam logic CSR_PORT_COUNT = 1'b1;

   typedef struct packed {
      logic [TIME_W-1:0] age_limit;
      logic [PCNT_W-1:0] port_count;
   } cfg_type;

   typedef struct packed {
      logic [MAC_W-1:0]  dest_mac;
      logic [MAC_W-1:0]  src_mac;
      logic [PORT_W-1:0] ingress_port;
      logic [TIME_W-1:0] now;
      logic [MASK_W-1:0] flood_mask;
      logic              group;
      logic              same_mac;
   } item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LEARN,
      ST_RESULT
   } state_type;
endpackage
`default_nettype wire

>>> src/mlf_ram.sv
`default_nettype none
module mlf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wen,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end
endmodule
`default_nettype wire

>>> src/mlf_front.sv
`default_nettype none
module mlf_front #(
   parameter int MAX_PORTS = mlf_pkg::MAX_PORTS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire mlf_pkg::cfg_type          cfg,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [mlf_pkg::REQ_W-1:0] req_tdata,
   output logic                           q_valid,
   input  wire logic                      q_ready,
   output mlf_pkg::item_type              q_item
);
   mlf_pkg::item_type slot_ff [2];
   logic wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   mlf_pkg::item_type item_in;
   logic [mlf_pkg::PCNT_W-1:0] pc;
   logic push, pop;

   always_comb begin
      item_in.dest_mac     = req_tdata[47:0];
      item_in.src_mac      = req_tdata[95:48];
      item_in.ingress_port = req_tdata[99:96];
      item_in.now          = req_tdata[131:100];
      item_in.group        = req_tdata[40];
      item_in.same_mac     = (req_tdata[47:0] == req_tdata[95:48]);
      pc = (cfg.port_count > mlf_pkg::PCNT_W'(MAX_PORTS)) ?
           mlf_pkg::PCNT_W'(MAX_PORTS) : cfg.port_count;
      for (int p = 0; p < mlf_pkg::MASK_W; p++) begin
         item_in.flood_mask[p] = (mlf_pkg::PCNT_W'(p) < pc) &&
                                 (req_tdata[99:96] != mlf_pkg::PORT_W'(p));
      end
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign q_valid    = (cnt_ff != 2'd0);
   assign q_item     = slot_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = q_valid && q_ready;
   assign wr_ptr_in  = push ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in  = pop ? !rd_ptr_ff : rd_ptr_ff;
   assign cnt_in     = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end
endmodule
`default_nettype wire

>>> src/mlf_back.sv
`default_nettype none
module mlf_back #(
   parameter int TABLE_ENTRIES = mlf_pkg::TABLE_ENTRIES_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire mlf_pkg::cfg_type          cfg,
   input  wire logic                      q_valid,
   output logic                           q_ready,
   input  wire mlf_pkg::item_type         q_item,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [mlf_pkg::RSP_W-1:0]      rsp_tdata
);
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   mlf_pkg::state_type st_ff, st_in;
   mlf_pkg::item_type  item_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [IDX_W:0]   rd_idx_ff;
   logic             pend_ff;
   logic [IDX_W-1:0] pend_idx_ff;
   logic             s_found_ff, d_found_ff, free_found_ff, dropped_ff;
   logic [IDX_W-1:0] s_idx_ff, d_idx_ff, free_idx_ff;
   logic [mlf_pkg::PORT_W-1:0] s_port_ff, d_port_ff;
   logic [mlf_pkg::TIME_W-1:0] d_last_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [mlf_pkg::RSP_W-1:0] rsp_data_ff;

   logic             wen;
   logic [IDX_W-1:0] waddr, raddr;
   logic [mlf_pkg::ENTRY_W-1:0] wdata, rdata;
   logic [mlf_pkg::MAC_W-1:0]  r_mac;
   logic [mlf_pkg::PORT_W-1:0] r_port;
   logic [mlf_pkg::TIME_W-1:0] r_last, age;
   logic scan_done, out_free, aged, flood;
   logic [mlf_pkg::MASK_W-1:0] mask;

   mlf_ram #(.WIDTH(mlf_pkg::ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
      .clock(clock), .wen(wen), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata_ff(rdata)
   );

   assign {r_mac, r_port, r_last} = rdata;
   assign scan_done  = (rd_idx_ff == (IDX_W+1)'(TABLE_ENTRIES)) && !pend_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign age        = item_ff.now - d_last_ff;
   assign aged       = d_found_ff && (age > cfg.age_limit);
   assign flood      = !(d_found_ff && !aged) || item_ff.group;
   assign mask       = flood ? item_ff.flood_mask : (mlf_pkg::MASK_W'(1) << d_port_ff);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_valid_in = ((st_ff == mlf_pkg::ST_RESULT) && out_free) ||
                         (rsp_valid_ff && !rsp_tready);

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         mlf_pkg::ST_IDLE:   if (q_valid) st_in = mlf_pkg::ST_SCAN;
         mlf_pkg::ST_SCAN:   if (scan_done) st_in = mlf_pkg::ST_LEARN;
         mlf_pkg::ST_LEARN:  st_in = mlf_pkg::ST_RESULT;
         mlf_pkg::ST_RESULT: if (out_free) st_in = mlf_pkg::ST_IDLE;
         default:            st_in = mlf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      q_ready = 1'b0;
      wen     = 1'b0;
      waddr   = free_idx_ff;
      wdata   = {item_ff.src_mac, item_ff.ingress_port, item_ff.now};
      raddr   = rd_idx_ff[IDX_W-1:0];
      unique case (st_ff)
         mlf_pkg::ST_IDLE: q_ready = 1'b1;
         mlf_pkg::ST_LEARN: begin
            if (s_found_ff) begin
               wen   = 1'b1;
               waddr = s_idx_ff;
               wdata = {item_ff.src_mac, s_port_ff, item_ff.now};
            end else if (free_found_ff) begin
               wen = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= mlf_pkg::ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
         unique case (st_ff)
            mlf_pkg::ST_IDLE: begin
               pend_ff <= 1'b0;
               if (q_valid) begin
                  item_ff       <= q_item;
                  rd_idx_ff     <= '0;
                  s_found_ff    <= 1'b0;
                  d_found_ff    <= 1'b0;
                  free_found_ff <= 1'b0;
                  dropped_ff    <= 1'b0;
               end
            end
            mlf_pkg::ST_SCAN: begin
               // read issued here, compared in the following cycle
               if (rd_idx_ff != (IDX_W+1)'(TABLE_ENTRIES)) begin
                  rd_idx_ff   <= rd_idx_ff + 1'b1;
                  pend_ff     <= 1'b1;
                  pend_idx_ff <= rd_idx_ff[IDX_W-1:0];
               end else begin
                  pend_ff <= 1'b0;
               end
               if (pend_ff) begin
                  if (valid_ff[pend_idx_ff]) begin
                     if (!s_found_ff && r_mac == item_ff.src_mac) begin
                        s_found_ff <= 1'b1;
                        s_idx_ff   <= pend_idx_ff;
                        s_port_ff  <= r_port;
                     end
                     if (!d_found_ff && r_mac == item_ff.dest_mac) begin
                        d_found_ff <= 1'b1;
                        d_idx_ff   <= pend_idx_ff;
                        d_port_ff  <= r_port;
                        d_last_ff  <= r_last;
                     end
                  end else if (!free_found_ff) begin
                     free_found_ff <= 1'b1;
                     free_idx_ff   <= pend_idx_ff;
                  end
               end
            end
            mlf_pkg::ST_LEARN: begin
               if (!s_found_ff && free_found_ff) valid_ff[free_idx_ff] <= 1'b1;
               dropped_ff <= !s_found_ff && !free_found_ff;
               // destination equal to source sees the just-learned entry
               if (item_ff.same_mac) begin
                  d_found_ff <= s_found_ff || free_found_ff;
                  d_idx_ff   <= s_found_ff ? s_idx_ff : free_idx_ff;
                  d_port_ff  <= s_found_ff ? s_port_ff : item_ff.ingress_port;
                  d_last_ff  <= item_ff.now;
               end
            end
            mlf_pkg::ST_RESULT: begin
               if (out_free) begin
                  if (aged) valid_ff[d_idx_ff] <= 1'b0;
                  rsp_data_ff  <= {5'd0, dropped_ff, aged, flood, mask};
               end
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

>>> src/mac_learning_forwarder.sv
// the back end handles one header at a time, sweeping the single table read port
//   once per header
// a two-entry queue lets the next header arrive while one is in the sweep
// reset: synchronous, clears the table valid bits, queue and output register,
//   age_limit to all ones and port_count to 16
`default_nettype none
`include "assert_macros.svh"
module mac_learning_forwarder #(
   parameter int TABLE_ENTRIES = mlf_pkg::TABLE_ENTRIES_DEF,
   parameter int MAX_PORTS     = mlf_pkg::MAX_PORTS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wen,
   input  wire logic                      csr_addr,
   input  wire logic [31:0]               csr_wdata,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // dest_mac[47:0], src_mac[95:48], ingress_port[99:96], now[131:100]
   input  wire logic [mlf_pkg::REQ_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // egress_mask[15:0], flooded[16], dest_aged_out[17], learn_dropped[18]
   output logic [mlf_pkg::RSP_W-1:0]      rsp_tdata
);
   mlf_pkg::cfg_type  cfg_ff;
   mlf_pkg::item_type q_item;
   logic q_valid, q_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.age_limit  <= '1;
         cfg_ff.port_count <= mlf_pkg::PCNT_W'(16);
      end else if (csr_wen) begin
         unique case (csr_addr)
            mlf_pkg::CSR_AGE_LIMIT:  cfg_ff.age_limit  <= csr_wdata;
            mlf_pkg::CSR_PORT_COUNT: cfg_ff.port_count <= csr_wdata[mlf_pkg::PCNT_W-1:0];
            default: ;
         endcase
      end
   end

   mlf_front #(.MAX_PORTS(MAX_PORTS)) u_front (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
   );

   mlf_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   `ASSERT_SAME(a_hit_onehot, clock, reset, rsp_tvalid && !rsp_tdata[16], $onehot(rsp_tdata[15:0]))
   `ASSERT_NEXT(a_one_at_a_time, clock, reset, q_valid && q_ready, !q_ready)
   `ASSERT_SAME(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[23:19] == 5'd0)
endmodule
`default_nettype wire
